@@ hw/rtl/bdeq_pkg.sv @@
// ----------------------------------------------------------------------------
// Button debounce event queue package
// Request codes, button classification codes, register indexes and the
// command bundle that drives the event queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bdeq_pkg;

    // Request carried by an input item
    typedef enum logic [1:0] {
        REQ_SAMPLE = 2'd0,
        REQ_POP    = 2'd1,
        REQ_CLEAR  = 2'd2,
        REQ_NONE   = 2'd3
    } t_req;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_ENABLED_MASK  = 2'd0,
        CFG_INVERT_LEVELS = 2'd1,
        CFG_LOCKOUT_MS    = 2'd2,
        CFG_UNUSED        = 2'd3
    } t_cfg_idx;

    // Per-button classification of a popped event
    localparam logic [1:0] CODE_PRESSED       = 2'd0;
    localparam logic [1:0] CODE_RELEASED      = 2'd1;
    localparam logic [1:0] CODE_STILL_PRESSED = 2'd2;
    localparam logic [1:0] CODE_STILL_RELEASED = 2'd3;

    localparam int unsigned LEVEL_W   = 8;
    localparam int unsigned CODES_W   = 16;
    localparam int unsigned TIME_W    = 32;
    localparam int unsigned LOCKOUT_W = 16;
    localparam int unsigned PENDING_W = 5;

    localparam logic [LEVEL_W-1:0]   ENABLED_RESET = 8'hFF;
    localparam logic [LOCKOUT_W-1:0] LOCKOUT_RESET = 16'd50;

    // Queue command for one step; at most one member is set
    typedef struct packed {
        logic push;
        logic pop;
        logic clear;
    } t_fifo_cmd;

endpackage

@@ hw/rtl/bdeq_lane.sv @@
// ----------------------------------------------------------------------------
// Button debounce lane
// Holds the time of the last accepted change of one button and decides
// whether a new level may be accepted.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bdeq_lane (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_use,
    input  logic                               i_level,
    input  logic                               i_old,
    input  logic [bdeq_pkg::TIME_W-1:0]        i_now,
    input  logic [bdeq_pkg::LOCKOUT_W-1:0]     i_lockout,
    input  logic                               i_commit,
    output logic                               o_change
);

    logic [bdeq_pkg::TIME_W-1:0] r_last;
    logic [bdeq_pkg::TIME_W-1:0] w_elapsed;

    // Wrapping difference handles timer rollover
    assign w_elapsed = i_now - r_last;
    assign o_change  = i_use && (i_level != i_old) &&
                       (w_elapsed >= {{(bdeq_pkg::TIME_W-bdeq_pkg::LOCKOUT_W){1'b0}},
                                      i_lockout});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last <= '0;
        end else if (i_commit && o_change) begin
            r_last <= i_now;
        end
    end

endmodule

@@ hw/rtl/bdeq_fifo.sv @@
// ----------------------------------------------------------------------------
// Button debounce event FIFO
// Circular queue of accepted level vectors with a registered, prefetched
// read of the head entry.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bdeq_fifo #(
    parameter int unsigned DEPTH = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  bdeq_pkg::t_fifo_cmd                i_cmd,
    input  logic [bdeq_pkg::LEVEL_W-1:0]       i_wdata,
    output logic [bdeq_pkg::LEVEL_W-1:0]       o_rdata,
    output logic                               o_empty,
    output logic                               o_full,
    output logic [$clog2(DEPTH+1)-1:0]         o_count_nxt
);

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    logic [bdeq_pkg::LEVEL_W-1:0] mem [DEPTH];
    logic [bdeq_pkg::LEVEL_W-1:0] r_rdata;
    logic [AW-1:0] r_head, n_head;
    logic [AW-1:0] r_tail, n_tail;
    logic [CW-1:0] r_count, n_count;

    assign o_empty     = (r_count == '0);
    assign o_full      = (r_count == FULL_COUNT);
    assign o_rdata     = r_rdata;
    assign o_count_nxt = n_count;

    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        if (i_cmd.clear) begin
            n_head  = '0;
            n_tail  = '0;
            n_count = '0;
        end else if (i_cmd.push) begin
            n_tail  = (r_tail == LAST_SLOT) ? '0 : r_tail + 1'b1;
            n_count = r_count + 1'b1;
        end else if (i_cmd.pop) begin
            n_head  = (r_head == LAST_SLOT) ? '0 : r_head + 1'b1;
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    // Prefetch the next head entry; forward a write to that same slot
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            mem[r_tail] <= i_wdata;
        end
        if (i_cmd.push && (r_tail == n_head)) begin
            r_rdata <= i_wdata;
        end else begin
            r_rdata <= mem[n_head];
        end
    end

endmodule

@@ hw/rtl/button_debounce_event_queue_unit.sv @@
// ----------------------------------------------------------------------------
// Button debounce event queue unit
// Debounces up to eight buttons with a per-button lockout time, queues every
// accepted level change unless full, and classifies queued events on pop.
//
// Usage:
//   Input channel (i_valid / o_ready) carries one request item: a pin sample
//   stamped with the millisecond time, a pop of the oldest event, or a clear.
//   Output channel (o_valid / i_ready) returns exactly one result item per
//   request, in order.
//   Each request passes through the input register, then the result
//   register, which holds its result item until the receiver takes it.
//   Throughput: one item per cycle while the receiver does not stall, set
//   by the single pass of lane compares and queue update between them.
//   The configuration port (i_cfg_we / i_cfg_idx / i_cfg_wdata) writes one
//   register per cycle, to be used only while the unit is idle (unchecked).
//   Reset (synchronous, active low) releases all buttons, zeroes the change
//   times, empties the queue and restores the register defaults.
//   When the receiver stalls, the result register holds its item and the
//   input register still takes one more item; after that o_ready drops.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module button_debounce_event_queue_unit #(
    parameter int unsigned BUTTON_COUNT = 8,
    parameter int unsigned QUEUE_DEPTH  = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // configuration
    input  logic                                  i_cfg_we,
    input  logic [1:0]                            i_cfg_idx,
    input  logic [bdeq_pkg::LOCKOUT_W-1:0]        i_cfg_wdata,
    // request channel
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic [1:0]                            i_req_type,
    input  logic [bdeq_pkg::LEVEL_W-1:0]          i_pin_levels,
    input  logic [bdeq_pkg::TIME_W-1:0]           i_now_ms,
    // result channel
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic                                  o_event_valid,
    output logic [bdeq_pkg::CODES_W-1:0]          o_button_codes,
    output logic [bdeq_pkg::LEVEL_W-1:0]          o_accepted_levels,
    output logic [bdeq_pkg::PENDING_W-1:0]        o_events_pending,
    output logic                                  o_overflow
);

    localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [bdeq_pkg::LEVEL_W-1:0] BUTTON_MASK =
        bdeq_pkg::LEVEL_W'((9'd1 << BUTTON_COUNT) - 9'd1);

    // configuration registers
    logic [bdeq_pkg::LEVEL_W-1:0]   r_enabled;
    logic                           r_invert;
    logic [bdeq_pkg::LOCKOUT_W-1:0] r_lockout;

    // input register
    logic                           r_in_valid;
    bdeq_pkg::t_req                 r_in_req;
    logic [bdeq_pkg::LEVEL_W-1:0]   r_in_pins;
    logic [bdeq_pkg::TIME_W-1:0]    r_in_now;

    // debounce state
    logic [bdeq_pkg::LEVEL_W-1:0]   r_accepted, n_accepted;
    logic [bdeq_pkg::LEVEL_W-1:0]   r_popref,   n_popref;

    // result register
    logic                           r_out_valid;
    logic                           r_out_event;
    logic [bdeq_pkg::CODES_W-1:0]   r_out_codes;
    logic [bdeq_pkg::LEVEL_W-1:0]   r_out_levels;
    logic [bdeq_pkg::PENDING_W-1:0] r_out_pending;
    logic                           r_out_ovf;

    logic                           w_adv;
    logic                           w_take;
    logic                           w_go;
    logic [bdeq_pkg::LEVEL_W-1:0]   w_use;
    logic [bdeq_pkg::LEVEL_W-1:0]   w_pressed;
    logic [bdeq_pkg::LEVEL_W-1:0]   w_chg;
    logic [bdeq_pkg::LEVEL_W-1:0]   w_next;
    logic                           w_changed;
    logic                           w_pop_ok;
    logic                           w_ovf;
    logic [bdeq_pkg::CODES_W-1:0]   w_codes;
    bdeq_pkg::t_fifo_cmd            w_cmd;
    logic [bdeq_pkg::LEVEL_W-1:0]   w_head;
    logic                           w_empty;
    logic                           w_full;
    logic [CW-1:0]                  w_count_nxt;
    logic [CW+bdeq_pkg::PENDING_W-1:0] w_count_ext;

    // Advance the processing stage whenever the result register is free
    assign w_adv   = !r_out_valid || i_ready;
    assign o_ready = !r_in_valid || w_adv;
    assign w_take  = i_valid && o_ready;
    assign w_go    = w_adv && r_in_valid;

    // ---------------------------------------------------------------- config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled <= bdeq_pkg::ENABLED_RESET;
            r_invert  <= 1'b0;
            r_lockout <= bdeq_pkg::LOCKOUT_RESET;
        end else if (i_cfg_we) begin
            unique case (bdeq_pkg::t_cfg_idx'(i_cfg_idx))
                bdeq_pkg::CFG_ENABLED_MASK:  r_enabled <= i_cfg_wdata[bdeq_pkg::LEVEL_W-1:0];
                bdeq_pkg::CFG_INVERT_LEVELS: r_invert  <= i_cfg_wdata[0];
                bdeq_pkg::CFG_LOCKOUT_MS:    r_lockout <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------- input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_take) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_in_req  <= bdeq_pkg::t_req'(i_req_type);
            r_in_pins <= i_pin_levels;
            r_in_now  <= i_now_ms;
        end
    end

    // -------------------------------------------------------- debounce lanes
    assign w_use     = r_enabled & BUTTON_MASK;
    assign w_pressed = r_invert ? ~r_in_pins : r_in_pins;

    for (genvar g = 0; g < bdeq_pkg::LEVEL_W; g++) begin : g_lane
        if (g < BUTTON_COUNT) begin : g_used
            bdeq_lane u_lane (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_use     (w_use[g]),
                .i_level   (w_pressed[g]),
                .i_old     (r_accepted[g]),
                .i_now     (r_in_now),
                .i_lockout (r_lockout),
                .i_commit  (w_go && (r_in_req == bdeq_pkg::REQ_SAMPLE)),
                .o_change  (w_chg[g])
            );
        end else begin : g_absent
            assign w_chg[g] = 1'b0;
        end
    end

    // Unused buttons drop to released in a new vector; others take the new
    // level only when their lane allows the change
    always_comb begin
        for (int i = 0; i < bdeq_pkg::LEVEL_W; i++) begin
            w_next[i] = w_use[i] && (w_chg[i] ? w_pressed[i] : r_accepted[i]);
        end
    end
    assign w_changed = |w_chg;

    // ------------------------------------------------------------ queue ctrl
    always_comb begin
        w_cmd      = '0;
        w_ovf      = 1'b0;
        w_pop_ok   = 1'b0;
        n_accepted = r_accepted;
        n_popref   = r_popref;
        if (w_go) begin
            unique case (r_in_req)
                bdeq_pkg::REQ_SAMPLE: begin
                    if (w_changed) begin
                        n_accepted = w_next;
                        w_cmd.push = !w_full;
                        w_ovf      = w_full;
                    end
                end
                bdeq_pkg::REQ_POP: begin
                    w_pop_ok  = !w_empty;
                    w_cmd.pop = !w_empty;
                    if (!w_empty) begin
                        n_popref = w_head;
                    end
                end
                bdeq_pkg::REQ_CLEAR: begin
                    w_cmd.clear = 1'b1;
                end
                default: ;
            endcase
        end
    end

    // Classify the head event against the previously popped vector
    always_comb begin
        w_codes = '0;
        for (int i = 0; i < bdeq_pkg::LEVEL_W; i++) begin
            if (w_pop_ok && (i < BUTTON_COUNT)) begin
                if (w_head[i] != r_popref[i]) begin
                    w_codes[2*i +: 2] = w_head[i] ? bdeq_pkg::CODE_PRESSED
                                                  : bdeq_pkg::CODE_RELEASED;
                end else begin
                    w_codes[2*i +: 2] = w_head[i] ? bdeq_pkg::CODE_STILL_PRESSED
                                                  : bdeq_pkg::CODE_STILL_RELEASED;
                end
            end
        end
    end

    bdeq_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_wdata     (w_next),
        .o_rdata     (w_head),
        .o_empty     (w_empty),
        .o_full      (w_full),
        .o_count_nxt (w_count_nxt)
    );

    // Pending count after this update; its low five bits form the field
    assign w_count_ext = {{bdeq_pkg::PENDING_W{1'b0}}, w_count_nxt};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accepted <= '0;
            r_popref   <= '0;
        end else begin
            r_accepted <= n_accepted;
            r_popref   <= n_popref;
        end
    end

    // --------------------------------------------------------- result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_go) begin
            r_out_event   <= w_pop_ok;
            r_out_codes   <= w_codes;
            r_out_levels  <= n_accepted;
            r_out_pending <= w_count_ext[bdeq_pkg::PENDING_W-1:0];
            r_out_ovf     <= w_ovf;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_event_valid     = r_out_event;
    assign o_button_codes    = r_out_codes;
    assign o_accepted_levels = r_out_levels;
    assign o_events_pending  = r_out_pending;
    assign o_overflow        = r_out_ovf;

    // ------------------------------------------------------------ assertions
    a_no_push_when_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_cmd.push && w_full))
        else $error("push issued into a full event queue");

    a_clear_empties : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_go && (r_in_req == bdeq_pkg::REQ_CLEAR)) |=> w_empty)
        else $error("queue not empty after clear");

    a_ovf_excl_event : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_overflow && o_event_valid))
        else $error("overflow and popped event in one result");

    a_pop_needs_entry : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.pop |-> !w_empty)
        else $error("pop from an empty event queue");

endmodule
